// ===== rtl/mcbp_pkg.sv =====
`default_nettype none

package mcbp_pkg;

    localparam int CHANNELS_DEFAULT  = 4;
    localparam int TIME_BITS_DEFAULT = 16;
    localparam int MAX_CHANNELS      = 4;
    localparam int FIELD_BITS        = 16;
    localparam int MODE_BITS         = 3;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_ADDR_BITS     = 6;
    localparam int CFG_INDEX_BITS    = 3;

    localparam logic [1:0] PULSE_TOGGLES = 2'd2;

    typedef enum logic [2:0] {
        MODE_LOW        = 3'd0,
        MODE_HIGH       = 3'd1,
        MODE_SYMMETRIC  = 3'd2,
        MODE_ASYMMETRIC = 3'd3,
        MODE_PULSE_LOW  = 3'd4,
        MODE_PULSE_HIGH = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_START       = 2'd1,
        FUNC_START_WIDTH = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_MODES   = 3'd0,
        REG_ENABLED_MASK    = 3'd1,
        REG_INITIAL_LEVELS  = 3'd2,
        REG_PERIOD_WORDS    = 3'd3,
        REG_HIGH_TIME_WORDS = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic       level;
        logic [1:0] toggles;
        logic       hold;
    } chan_state_t;

endpackage

`default_nettype wire

// ===== rtl/mcbp_chan.sv =====
`default_nettype none

module mcbp_chan #(
    parameter int TIME_BITS = mcbp_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                tick_en,
    input  wire logic                                start,
    input  wire logic [mcbp_pkg::MODE_BITS-1:0]      mode,
    input  wire logic [mcbp_pkg::FIELD_BITS-1:0]     period_field,
    input  wire logic [mcbp_pkg::FIELD_BITS-1:0]     high_field,
    input  wire logic                                ovr_valid,
    input  wire logic [mcbp_pkg::FIELD_BITS-1:0]     ovr_width,
    input  wire logic [TIME_BITS-1:0]                time_now,
    input  wire mcbp_pkg::chan_state_t               state,
    input  wire logic [TIME_BITS-1:0]                last_toggle,
    output mcbp_pkg::chan_state_t                    state_next,
    output logic [TIME_BITS-1:0]                     last_toggle_next,
    output logic                                     hit
);

    logic [mcbp_pkg::FIELD_BITS-1:0] period;
    logic [mcbp_pkg::FIELD_BITS-1:0] high_time;
    logic [mcbp_pkg::FIELD_BITS-1:0] low_time;
    logic [mcbp_pkg::FIELD_BITS-1:0] wait_time;
    logic [TIME_BITS-1:0]            elapsed;
    logic                            due;
    logic                            timed;
    mcbp_pkg::mode_t                 mode_sel;

    assign mode_sel = mcbp_pkg::mode_t'(mode);

    always_comb
    begin
        if (ovr_valid)
        begin
            period    = ovr_width;
            high_time = ovr_width;
        end
        else
        begin
            period    = period_field;
            high_time = (high_field > period_field) ? period_field : high_field;
        end
        low_time = period - high_time;
        elapsed  = time_now - last_toggle;
    end

    always_comb
    begin
        timed     = 1'b0;
        wait_time = period;
        case (mode_sel)
            mcbp_pkg::MODE_SYMMETRIC:
            begin
                timed     = 1'b1;
                wait_time = period;
            end
            mcbp_pkg::MODE_ASYMMETRIC, mcbp_pkg::MODE_PULSE_HIGH:
            begin
                timed     = (mode_sel == mcbp_pkg::MODE_ASYMMETRIC) ||
                            (state.toggles < mcbp_pkg::PULSE_TOGGLES);
                wait_time = state.level ? high_time : low_time;
            end
            mcbp_pkg::MODE_PULSE_LOW:
            begin
                timed     = state.toggles < mcbp_pkg::PULSE_TOGGLES;
                wait_time = state.level ? low_time : high_time;
            end
            default:
            begin
                timed     = 1'b0;
                wait_time = period;
            end
        endcase
        due = timed && (mcbp_pkg::FIELD_BITS'(elapsed) >= wait_time);
    end

    always_comb
    begin
        state_next       = state;
        last_toggle_next = last_toggle;
        hit              = 1'b0;
        if (start)
        begin
            state_next.level   = (mode_sel == mcbp_pkg::MODE_PULSE_LOW);
            state_next.toggles = 2'd0;
            hit                = 1'b1;
        end
        else if (tick_en)
        begin
            case (mode_sel)
                mcbp_pkg::MODE_LOW, mcbp_pkg::MODE_HIGH:
                begin
                    if (state.hold)
                    begin
                        state_next.level = mode[0];
                        state_next.hold  = 1'b0;
                        hit              = 1'b1;
                    end
                end
                default:
                begin
                    if (due)
                    begin
                        state_next.level = ~state.level;
                        last_toggle_next = time_now;
                        hit              = 1'b1;
                        if (mode_sel == mcbp_pkg::MODE_PULSE_LOW ||
                            mode_sel == mcbp_pkg::MODE_PULSE_HIGH)
                        begin
                            state_next.toggles = state.toggles + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multi_channel_blink_pulse_generator.sv =====
`default_nettype none

// A bank of up to four binary outputs, each blinking, held or firing one-shot pulses as set by
// its 3-bit mode. Every request is taken through an input register and a result register, so a
// new request is accepted in every cycle while the result register is free or being read; one
// pass of the per-channel compare logic lies between the two registers, and the result is
// presented from the result register. Tick requests advance the time counter and update all
// enabled channels at once; start requests arm a pulse and report a refusal in tuser when the
// channel is not in a pulse mode.
// Registers lie at byte addresses 0, 8, 16, 24 and 32 in the order modes, enable mask,
// initial levels, periods and high times; they should be written only while no request is
// in flight.

module multi_channel_blink_pulse_generator #(
    parameter int CHANNELS  = mcbp_pkg::CHANNELS_DEFAULT,
    parameter int TIME_BITS = mcbp_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [23:0]                           s_axis_tdata,  // channel, pulse_width
    input  wire logic [1:0]                            s_axis_tuser,  // func
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [7:0]                                 m_axis_tdata,  // levels, changed
    output logic                                       m_axis_tuser,  // status
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mcbp_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  wire logic [mcbp_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [mcbp_pkg::CFG_DATA_BITS-1:0]         prdata,
    output logic                                       pready
);

    localparam int FB = mcbp_pkg::FIELD_BITS;
    localparam int MB = mcbp_pkg::MODE_BITS;
    localparam int MC = mcbp_pkg::MAX_CHANNELS;

    logic [MB*MC-1:0]                     modes_reg;
    logic [MC-1:0]                        enabled_reg;
    logic [MC-1:0]                        init_levels_reg;
    logic [FB*MC-1:0]                     period_reg;
    logic [FB*MC-1:0]                     high_reg;

    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    mcbp_pkg::func_t                      func_reg;
    logic [1:0]                           channel_reg;
    logic [FB-1:0]                        width_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [MC-1:0]                        levels_reg;
    logic [MC-1:0]                        levels_next;
    logic [MC-1:0]                        changed_reg;
    logic [MC-1:0]                        changed_next;
    logic                                 status_reg;
    logic                                 status_next;

    logic [TIME_BITS-1:0]                 time_reg;
    logic [TIME_BITS-1:0]                 time_next;
    mcbp_pkg::chan_state_t                chan_reg       [CHANNELS];
    mcbp_pkg::chan_state_t                chan_next      [CHANNELS];
    logic [TIME_BITS-1:0]                 last_reg       [CHANNELS];
    logic [TIME_BITS-1:0]                 last_next      [CHANNELS];
    logic [CHANNELS-1:0]                  ovr_valid_reg;
    logic [CHANNELS-1:0]                  ovr_valid_next;
    logic [FB-1:0]                        ovr_reg        [CHANNELS];
    logic [FB-1:0]                        ovr_next       [CHANNELS];

    mcbp_pkg::chan_state_t                chan_upd       [CHANNELS];
    logic [TIME_BITS-1:0]                 last_upd       [CHANNELS];
    logic [CHANNELS-1:0]                  hit;
    logic [CHANNELS-1:0]                  start_ok;

    logic                                 in_accept;
    logic                                 advance;
    logic                                 is_tick;
    logic                                 is_start;
    logic                                 cfg_wr;
    mcbp_pkg::reg_index_t                 cfg_index;

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign is_tick  = (func_reg == mcbp_pkg::FUNC_TICK);
    assign is_start = (func_reg == mcbp_pkg::FUNC_START) ||
                      (func_reg == mcbp_pkg::FUNC_START_WIDTH);

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_index = mcbp_pkg::reg_index_t'(paddr[5:3]);

    assign time_next = is_tick ? time_reg + TIME_BITS'(1) : time_reg;

    genvar gc;
    generate
        for (gc = 0; gc < CHANNELS; gc++)
        begin : g_chan
            logic [MB-1:0] mode_c;

            assign mode_c = modes_reg[MB*gc +: MB];
            assign start_ok[gc] = is_start && (channel_reg == 2'(gc)) &&
                                  (mcbp_pkg::mode_t'(mode_c) == mcbp_pkg::MODE_PULSE_LOW ||
                                   mcbp_pkg::mode_t'(mode_c) == mcbp_pkg::MODE_PULSE_HIGH);

            mcbp_chan #(
                .TIME_BITS (TIME_BITS)
            ) u_chan (
                .tick_en          (is_tick && enabled_reg[gc]),
                .start            (start_ok[gc]),
                .mode             (mode_c),
                .period_field     (period_reg[FB*gc +: FB]),
                .high_field       (high_reg[FB*gc +: FB]),
                .ovr_valid        (ovr_valid_reg[gc]),
                .ovr_width        (ovr_reg[gc]),
                .time_now         (time_next),
                .state            (chan_reg[gc]),
                .last_toggle      (last_reg[gc]),
                .state_next       (chan_upd[gc]),
                .last_toggle_next (last_upd[gc]),
                .hit              (hit[gc])
            );
        end
    endgenerate

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        levels_next  = '0;
        changed_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            levels_next[c]  = chan_upd[c].level;
            changed_next[c] = hit[c];
        end
        status_next = is_start && !(|start_ok);
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_next[c]      = chan_reg[c];
            last_next[c]      = last_reg[c];
            ovr_valid_next[c] = ovr_valid_reg[c];
            ovr_next[c]       = ovr_reg[c];
            if (cfg_wr)
            begin
                case (cfg_index)
                    mcbp_pkg::REG_CHANNEL_MODES:
                    begin
                        chan_next[c].level   = init_levels_reg[c];
                        chan_next[c].hold    = 1'b1;
                        chan_next[c].toggles = mcbp_pkg::PULSE_TOGGLES;
                    end
                    mcbp_pkg::REG_PERIOD_WORDS, mcbp_pkg::REG_HIGH_TIME_WORDS:
                    begin
                        ovr_valid_next[c] = 1'b0;
                    end
                    default:
                    begin
                        ovr_valid_next[c] = ovr_valid_reg[c];
                    end
                endcase
            end
            else if (advance)
            begin
                chan_next[c] = chan_upd[c];
                last_next[c] = last_upd[c];
                if (start_ok[c] && func_reg == mcbp_pkg::FUNC_START_WIDTH)
                begin
                    ovr_valid_next[c] = 1'b1;
                    ovr_next[c]       = width_reg;
                end
            end
        end
    end

    always_comb
    begin
        case (cfg_index)
            mcbp_pkg::REG_CHANNEL_MODES:   prdata = 64'(modes_reg);
            mcbp_pkg::REG_ENABLED_MASK:    prdata = 64'(enabled_reg);
            mcbp_pkg::REG_INITIAL_LEVELS:  prdata = 64'(init_levels_reg);
            mcbp_pkg::REG_PERIOD_WORDS:    prdata = period_reg;
            mcbp_pkg::REG_HIGH_TIME_WORDS: prdata = high_reg;
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg       <= '0;
            enabled_reg     <= '0;
            init_levels_reg <= '0;
            period_reg      <= '0;
            high_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            time_reg        <= '0;
            ovr_valid_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_reg[c].level   <= 1'b0;
                chan_reg[c].toggles <= mcbp_pkg::PULSE_TOGGLES;
                chan_reg[c].hold    <= 1'b1;
                last_reg[c]         <= '0;
                ovr_reg[c]          <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    mcbp_pkg::REG_CHANNEL_MODES:   modes_reg       <= pwdata[MB*MC-1:0];
                    mcbp_pkg::REG_ENABLED_MASK:    enabled_reg     <= pwdata[MC-1:0];
                    mcbp_pkg::REG_INITIAL_LEVELS:  init_levels_reg <= pwdata[MC-1:0];
                    mcbp_pkg::REG_PERIOD_WORDS:    period_reg      <= pwdata;
                    mcbp_pkg::REG_HIGH_TIME_WORDS: high_reg        <= pwdata;
                    default:                       modes_reg       <= modes_reg;
                endcase
            end
            else if (advance)
            begin
                time_reg <= time_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ovr_valid_reg <= ovr_valid_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_reg[c] <= chan_next[c];
                last_reg[c] <= last_next[c];
                ovr_reg[c]  <= ovr_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg    <= mcbp_pkg::func_t'(s_axis_tuser);
            channel_reg <= s_axis_tdata[1:0];
            width_reg   <= s_axis_tdata[17:2];
        end
        if (advance)
        begin
            levels_reg  <= levels_next;
            changed_reg <= changed_next;
            status_reg  <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {changed_reg, levels_reg};
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
typedef struct packed {
    logic [3:0] levels;
    logic [3:0] changed;
    logic       status;
} blink_result_t;

class blink_scoreboard;
    logic [11:0]   modes;
    logic [3:0]    enables;
    logic [3:0]    init_levels;
    logic [63:0]   periods;
    logic [63:0]   highs;
    logic [15:0]   now;
    logic [3:0]    lvl;
    logic [15:0]   last_flip [4];
    logic [1:0]    flips [4];
    logic [3:0]    hold;
    logic [3:0]    ovr_valid;
    logic [15:0]   ovr_width [4];
    blink_result_t pending_results [$];
    int            errors;

    function new();
        modes = '0;
        enables = '0;
        init_levels = '0;
        periods = '0;
        highs = '0;
        now = '0;
        lvl = '0;
        hold = 4'hF;
        ovr_valid = '0;
        errors = 0;
        for (int c = 0; c < 4; c++)
        begin
            last_flip[c] = '0;
            flips[c] = mcbp_pkg::PULSE_TOGGLES;
            ovr_width[c] = '0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            mcbp_pkg::REG_CHANNEL_MODES:
            begin
                modes = value[11:0];
                lvl = init_levels;
                hold = 4'hF;
                for (int c = 0; c < 4; c++)
                    flips[c] = mcbp_pkg::PULSE_TOGGLES;
            end
            mcbp_pkg::REG_ENABLED_MASK:    enables = value[3:0];
            mcbp_pkg::REG_INITIAL_LEVELS:  init_levels = value[3:0];
            mcbp_pkg::REG_PERIOD_WORDS:
            begin
                periods = value;
                ovr_valid = '0;
            end
            mcbp_pkg::REG_HIGH_TIME_WORDS:
            begin
                highs = value;
                ovr_valid = '0;
            end
            default: ;
        endcase
    endfunction

    function logic [15:0] period_of(int c);
        if (ovr_valid[c])
            return ovr_width[c];
        return periods[16*c +: 16];
    endfunction

    function logic [15:0] high_of(int c);
        logic [15:0] h;
        logic [15:0] p;
        if (ovr_valid[c])
            return ovr_width[c];
        h = highs[16*c +: 16];
        p = period_of(c);
        return (h > p) ? p : h;
    endfunction

    function bit flip_if_due(int c, logic [15:0] wait_ticks);
        logic [15:0] elapsed;
        elapsed = now - last_flip[c];
        if (elapsed < wait_ticks)
            return 1'b0;
        last_flip[c] = now;
        lvl[c] = ~lvl[c];
        return 1'b1;
    endfunction

    function bit tick_channel(int c);
        logic [2:0]  m;
        logic [15:0] p;
        logic [15:0] h;
        bit          hit;
        m = modes[3*c +: 3];
        p = period_of(c);
        h = high_of(c);
        case (m)
            mcbp_pkg::MODE_LOW, mcbp_pkg::MODE_HIGH:
            begin
                if (!hold[c])
                    return 1'b0;
                lvl[c] = (m == mcbp_pkg::MODE_HIGH);
                hold[c] = 1'b0;
                return 1'b1;
            end
            mcbp_pkg::MODE_SYMMETRIC:  return flip_if_due(c, p);
            mcbp_pkg::MODE_ASYMMETRIC: return flip_if_due(c, lvl[c] ? h : p - h);
            mcbp_pkg::MODE_PULSE_LOW, mcbp_pkg::MODE_PULSE_HIGH:
            begin
                if (flips[c] >= mcbp_pkg::PULSE_TOGGLES)
                    return 1'b0;
                if (m == mcbp_pkg::MODE_PULSE_LOW)
                    hit = flip_if_due(c, lvl[c] ? p - h : h);
                else
                    hit = flip_if_due(c, lvl[c] ? h : p - h);
                if (hit)
                    flips[c] = flips[c] + 2'd1;
                return hit;
            end
            default: return 1'b0;
        endcase
    endfunction

    function void note_request(logic [1:0] f, logic [1:0] ch, logic [15:0] w);
        blink_result_t r;
        logic [2:0]    m;
        r = '0;
        if (f == mcbp_pkg::FUNC_TICK)
        begin
            now = now + 16'd1;
            for (int c = 0; c < 4; c++)
                if (enables[c])
                    if (tick_channel(c))
                        r.changed[c] = 1'b1;
        end
        else if (f == mcbp_pkg::FUNC_START || f == mcbp_pkg::FUNC_START_WIDTH)
        begin
            m = modes[3*ch +: 3];
            if (m != mcbp_pkg::MODE_PULSE_LOW && m != mcbp_pkg::MODE_PULSE_HIGH)
                r.status = 1'b1;
            else
            begin
                if (f == mcbp_pkg::FUNC_START_WIDTH)
                begin
                    ovr_width[ch] = w;
                    ovr_valid[ch] = 1'b1;
                end
                lvl[ch] = (m == mcbp_pkg::MODE_PULSE_LOW);
                flips[ch] = 2'd0;
                r.changed[ch] = 1'b1;
            end
        end
        r.levels = lvl;
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [3:0] levels, logic [3:0] changed, logic status);
        blink_result_t e;
        if (pending_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: levels %h changed %h status %b",
                         levels, changed, status);
            return;
        end
        e = pending_results.pop_front();
        if (e.levels !== levels || e.changed !== changed || e.status !== status)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected levels %h changed %h status %b, got %h %h %b",
                         e.levels, e.changed, e.status, levels, changed, status);
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module tb_top;
    localparam int         LIMIT          = 200000;
    localparam logic [2:0] UNUSED_REG     = 3'd5;
    localparam int         TIMES_TYPICAL  = 0;
    localparam int         TIMES_ZERO     = 1;
    localparam int         TIMES_MAX      = 2;
    localparam int         TIMES_CLAMPED  = 3;
    localparam int         PRESSURE_NONE  = 0;
    localparam int         PRESSURE_STALL = 1;
    localparam int         PRESSURE_PAUSE = 2;
    localparam int         FUNC_UNUSED    = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int send_idle_pct = 12;
    int recv_idle_pct = 69;
    int hold_off_cycles = 0;
    int cycle_count = 0;

    blink_scoreboard sb = new();

    multi_channel_blink_pulse_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_cycles--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tuser);

    task automatic send_request(input logic [1:0] f, input logic [1:0] ch,
                                input logic [15:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, w, ch};
        s_axis_tuser  <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(f, ch, w);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic cfg_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [63:0] random_times(int kind, bit is_high);
        logic [63:0] v;
        for (int c = 0; c < 4; c++)
        begin
            case (kind)
                TIMES_ZERO:    v[16*c +: 16] = '0;
                TIMES_MAX:     v[16*c +: 16] = 16'hFFFF;
                TIMES_CLAMPED: v[16*c +: 16] = is_high ? 16'($urandom) : 16'($urandom_range(1, 6));
                default:
                    if ($urandom_range(9) == 0)
                        v[16*c +: 16] = 16'($urandom);
                    else
                        v[16*c +: 16] = 16'($urandom_range(0, is_high ? 12 : 10));
            endcase
        end
        return v;
    endfunction

    task automatic random_setup(input int kind);
        logic [11:0] m;
        for (int c = 0; c < 4; c++)
            if ($urandom_range(1))
                m[3*c +: 3] = $urandom_range(1) ? mcbp_pkg::MODE_PULSE_LOW
                                                : mcbp_pkg::MODE_PULSE_HIGH;
            else
                m[3*c +: 3] = 3'($urandom_range(7));
        cfg_write(mcbp_pkg::REG_ENABLED_MASK,
                  ($urandom_range(3) == 0) ? 64'($urandom_range(15)) : 64'hF);
        cfg_write(mcbp_pkg::REG_PERIOD_WORDS, random_times(kind, 1'b0));
        cfg_write(mcbp_pkg::REG_HIGH_TIME_WORDS, random_times(kind, 1'b1));
        cfg_write(mcbp_pkg::REG_INITIAL_LEVELS, 64'($urandom_range(15)));
        cfg_write(mcbp_pkg::REG_CHANNEL_MODES, {52'($urandom), m});
        if ($urandom_range(1))
            cfg_write(mcbp_pkg::REG_INITIAL_LEVELS, 64'($urandom_range(15)));
        cfg_release();
    endtask

    task automatic send_random_request();
        int          r;
        logic [1:0]  f;
        logic [15:0] w;
        r = $urandom_range(99);
        if (r < 72)
            f = mcbp_pkg::FUNC_TICK;
        else if (r < 82)
            f = mcbp_pkg::FUNC_START;
        else if (r < 95)
            f = mcbp_pkg::FUNC_START_WIDTH;
        else
            f = 2'(FUNC_UNUSED);
        w = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 12)) : 16'($urandom);
        send_request(f, 2'($urandom_range(3)), w);
    endtask

    task automatic run_phase(input int kind, input int n_items, input int s_pct,
                             input int r_pct, input int pressure);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        random_setup(kind);
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
            begin
                if (pressure == PRESSURE_STALL)
                    hold_off_cycles = 150;
                else if (pressure == PRESSURE_PAUSE)
                    drain_results();
            end
            send_random_request();
        end
        drain_results();
    endtask

    task automatic run_directed_requests();
        cfg_write(mcbp_pkg::REG_INITIAL_LEVELS, 64'hA);
        cfg_write(mcbp_pkg::REG_ENABLED_MASK, 64'hF);
        cfg_write(mcbp_pkg::REG_PERIOD_WORDS, 64'h0003_0002_0004_0002);
        cfg_write(mcbp_pkg::REG_HIGH_TIME_WORDS, 64'h0005_0001_0001_0000);
        cfg_write(UNUSED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(mcbp_pkg::REG_CHANNEL_MODES, 64'hB1A);
        cfg_release();
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd3, 16'hFFFF);
        send_request(mcbp_pkg::FUNC_START, 2'd2, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_START_WIDTH, 2'd3, 16'hFFFF);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_START, 2'd3, 16'h0000);
        send_request(mcbp_pkg::FUNC_START_WIDTH, 2'd2, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_START, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_START_WIDTH, 2'd1, 16'h5555);
        send_request(2'(FUNC_UNUSED), 2'd1, 16'hAAAA);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        drain_results();
        cfg_write(mcbp_pkg::REG_PERIOD_WORDS, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(mcbp_pkg::REG_INITIAL_LEVELS, 64'h5);
        cfg_write(mcbp_pkg::REG_CHANNEL_MODES, 64'hF88);
        cfg_release();
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        send_request(mcbp_pkg::FUNC_START, 2'd3, 16'h0000);
        send_request(mcbp_pkg::FUNC_START_WIDTH, 2'd2, 16'h1234);
        send_request(mcbp_pkg::FUNC_TICK, 2'd0, 16'h0000);
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_requests();
        run_phase(TIMES_TYPICAL, 210, 12, 69, PRESSURE_STALL);
        run_phase(TIMES_ZERO,    210, 12, 69, PRESSURE_NONE);
        run_phase(TIMES_TYPICAL, 210, 12, 69, PRESSURE_NONE);
        run_phase(TIMES_TYPICAL, 210, 69, 12, PRESSURE_NONE);
        run_phase(TIMES_TYPICAL, 210, 69, 12, PRESSURE_PAUSE);
        run_phase(TIMES_MAX,     210, 69, 12, PRESSURE_NONE);
        run_phase(TIMES_TYPICAL, 210, 0, 0, PRESSURE_NONE);
        run_phase(TIMES_CLAMPED, 210, 0, 0, PRESSURE_NONE);
        run_phase(TIMES_TYPICAL, 210, 0, 0, PRESSURE_NONE);
        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== multi_channel_blink_pulse_generator.f =====
rtl/mcbp_pkg.sv
rtl/mcbp_chan.sv
rtl/multi_channel_blink_pulse_generator.sv
tb/tb_top.sv
